[rtl/number_to_ascii_formatter_unit_defines.svh]
// Assertion macro used by the formatter checker.
// No dependencies.
`ifndef NUMBER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
// Concurrent assertion, disabled while the active-low reset is low.
`define N2A_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

[rtl/n2a_pkg.sv]
// Package for the number to ASCII formatter: operation codes, command type.
// No dependencies.
package n2a_pkg;
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEX  = 3'd2;
  localparam logic [2:0] OP_PTR  = 3'd3;
  localparam logic [2:0] OP_SIZE = 3'd4;

  // classified command handed from front to back
  typedef struct packed {
    logic [63:0] mag;     // number to print
    logic        hex;     // 1 hex digits, 0 decimal
    logic        ptr;     // fixed 16 digits with separator
    logic        neg;     // leading '-'
    logic        size;    // append " xB"
    logic [7:0]  unit;    // unit letter, or 0 for plain " B"
  } n2a_cmd_t;

  localparam int QDEPTH = 2;
endpackage

[rtl/n2a_front.sv]
// Front: accepts input transactions and classifies them into commands.
// Depends on n2a_pkg.
module n2a_front import n2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [2:0]  operation,
  input  logic        wide,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output n2a_cmd_t    cmd
);
  logic     valid_r;
  n2a_cmd_t cmd_r, cmd_nxt;
  logic [63:0] v32, sx;
  logic [2:0] lvl;
  logic [5:0] sh;
  logic [64:0] q;

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    v32 = {32'd0, value[31:0]};
    sx  = wide ? value : {{32{value[31]}}, value[31:0]};
    if (value < 64'h400) lvl = 3'd0;
    else if (value < 64'h100000) lvl = 3'd1;
    else if (value < 64'h40000000) lvl = 3'd2;
    else if (value < 64'h10000000000) lvl = 3'd3;
    else if (value < 64'h4000000000000) lvl = 3'd4;
    else if (value < 64'h1000000000000000) lvl = 3'd5;
    else lvl = 3'd6;
    sh = 6'(10 * lvl);
    q = {1'b0, value >> sh};
    if (lvl != 3'd0) q = q + 65'((value >> (sh - 6'd1)) & 64'd1);
    cmd_nxt = '0;
    case (operation)
      OP_SDEC: begin
        cmd_nxt.neg = sx[63];
        cmd_nxt.mag = sx[63] ? (64'd0 - sx) : sx;
      end
      OP_UDEC: cmd_nxt.mag = wide ? value : v32;
      OP_HEX: begin
        cmd_nxt.hex = 1'b1;
        cmd_nxt.mag = wide ? value : v32;
      end
      OP_PTR: begin
        cmd_nxt.hex = 1'b1;
        cmd_nxt.ptr = 1'b1;
        cmd_nxt.mag = value;
      end
      default: begin
        cmd_nxt.size = 1'b1;
        cmd_nxt.mag  = q[63:0];
        case (lvl)
          3'd1: cmd_nxt.unit = "K";
          3'd2: cmd_nxt.unit = "M";
          3'd3: cmd_nxt.unit = "G";
          3'd4: cmd_nxt.unit = "T";
          3'd5: cmd_nxt.unit = "P";
          3'd6: cmd_nxt.unit = "E";
          default: cmd_nxt.unit = 8'd0;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_ready) valid_r <= in_valid && (operation <= OP_SIZE);
    if (in_ready && in_valid) cmd_r <= cmd_nxt;
  end
endmodule

[rtl/n2a_queue.sv]
// Short command queue between front and back.
// Depends on n2a_pkg.
module n2a_queue import n2a_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  n2a_cmd_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output n2a_cmd_t rd_data
);
  n2a_cmd_t mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != ($clog2(QDEPTH)+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

[rtl/n2a_back.sv]
// Back: bit-serial binary to BCD (double dabble), then character emission.
// Depends on n2a_pkg.
module n2a_back import n2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  n2a_cmd_t   cmd,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_char,
  output logic       out_last
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_CONV = 3'b010, S_EMIT = 3'b100
  } state_t;
  state_t st_r;
  n2a_cmd_t c_r;
  logic [63:0] sh_r;
  logic [79:0] bcd_r, adj;
  logic [6:0] cnt_r;
  logic [4:0] pos_r;     // digit index being sent, counting down
  logic [1:0] tail_r;    // 0 digits, 1 space, 2 unit, 3 'B'
  logic       sign_r, sep_r;
  logic [7:0] ch_r;
  logic       last_r, ov_r;
  logic [3:0] dig;
  logic [4:0] top;
  logic [7:0] ch_nxt;
  logic       last_nxt, adv;
  logic [1:0] tail_nxt;
  logic [4:0] pos_nxt;
  logic       sign_nxt, sep_nxt, done;

  assign cmd_ready  = st_r == S_IDLE;
  assign out_tvalid = ov_r;
  assign out_char   = ch_r;
  assign out_last   = last_r;

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  // highest nonzero digit position
  always_comb begin
    top = 5'd0;
    for (int i = 0; i < 20; i++) if (bcd_r[4*i +: 4] != 4'd0) top = 5'(i);
  end

  always_comb begin
    dig = c_r.hex ? c_r.mag[4*pos_r[3:0] +: 4] : bcd_r[4*pos_r +: 4];
    ch_nxt = 8'd0; last_nxt = 1'b0;
    tail_nxt = tail_r; pos_nxt = pos_r; sign_nxt = sign_r; sep_nxt = sep_r;
    done = 1'b0;
    if (sign_r) begin
      ch_nxt = "-"; sign_nxt = 1'b0;
    end else if (sep_r) begin
      ch_nxt = "_"; sep_nxt = 1'b0;
    end else if (tail_r == 2'd0) begin
      ch_nxt = 8'(dig) + ((dig < 4'd10) ? 8'd48 : 8'd87);
      if (pos_r == 5'd0) begin
        if (c_r.size) tail_nxt = 2'd1; else begin last_nxt = 1'b1; done = 1'b1; end
      end else begin
        pos_nxt = pos_r - 5'd1;
        if (c_r.ptr && pos_r == 5'd8) sep_nxt = 1'b1;
      end
    end else if (tail_r == 2'd1) begin
      ch_nxt = " ";
      tail_nxt = (c_r.unit == 8'd0) ? 2'd3 : 2'd2;
    end else if (tail_r == 2'd2) begin
      ch_nxt = c_r.unit; tail_nxt = 2'd3;
    end else begin
      ch_nxt = "B"; last_nxt = 1'b1; done = 1'b1;
    end
  end

  // no character goes out in the setup cycle that picks the top digit
  assign adv = st_r == S_EMIT && cnt_r != 7'd64 && (!ov_r || out_tready);

  logic [4:0] hpos;
  always_comb begin
    hpos = 5'd0;
    for (int i = 0; i < 16; i++) if (cmd.mag[4*i +: 4] != 4'd0) hpos = 5'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; cnt_r <= 7'd0;
    end else begin
      if (ov_r && out_tready && !adv) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (cmd_valid) begin
          c_r <= cmd; sign_r <= cmd.neg; sep_r <= 1'b0; tail_r <= 2'd0;
          if (cmd.hex) begin
            pos_r <= cmd.ptr ? 5'd15 : hpos;
            st_r <= S_EMIT;
          end else begin
            sh_r <= cmd.mag; bcd_r <= '0; cnt_r <= 7'd0;
            st_r <= S_CONV;
          end
        end
        S_CONV: begin
          bcd_r <= {adj[78:0], sh_r[63]};
          sh_r  <= {sh_r[62:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (cnt_r == 7'd64) begin
            pos_r <= top; cnt_r <= 7'd0;
          end else if (adv) begin
            ov_r <= 1'b1; ch_r <= ch_nxt; last_r <= last_nxt;
            tail_r <= tail_nxt; pos_r <= pos_nxt; sign_r <= sign_nxt; sep_r <= sep_nxt;
            if (done) st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/number_to_ascii_formatter_unit.sv]
// Number to ASCII formatter: hex/decimal/pointer/size text, one char per beat.
// The first char follows the front register, the queue and the back end's capture;
// decimal and size items then pass the bit-serial BCD conversion and a setup step that
// picks the top digit. Then one char a cycle while out_tready is high. The back end takes
// a new item only once it has loaded the last char of the last one. Codes 5..7 give no output.
// Reset (rst_n low, synchronous) empties the queue and idles the back end.
module number_to_ascii_formatter_unit import n2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // value[63:0], operation[66:64], wide[67], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // character[7:0]
  output logic        out_tlast
);
  logic fv, fr, bv, br;
  n2a_cmd_t fc, bc;
  n2a_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .value(in_tdata[63:0]), .operation(in_tdata[66:64]), .wide(in_tdata[67]),
    .cmd_valid(fv), .cmd_ready(fr), .cmd(fc));
  n2a_queue u_queue (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fc),
    .rd_valid(bv), .rd_ready(br), .rd_data(bc));
  n2a_back u_back (.clk, .rst_n, .cmd_valid(bv), .cmd_ready(br), .cmd(bc),
    .out_tvalid, .out_tready, .out_char(out_tdata), .out_last(out_tlast));
endmodule

[rtl/n2a_checker.sv]
// Port-level checker for the formatter, bound to the top level.
// Depends on number_to_ascii_formatter_unit_defines.svh.
`include "number_to_ascii_formatter_unit_defines.svh"
module n2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  `N2A_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "output changed while stalled")
  `N2A_ASSERT(a_ascii, clk, rst_n, out_tvalid |-> out_tdata != 8'd0 && !out_tdata[7], "non-ASCII char")
  `N2A_ASSERT(a_lastb, clk, rst_n, out_tvalid && out_tlast |-> (out_tdata >= 8'd48 && out_tdata <= 8'd57) || (out_tdata >= 8'd97 && out_tdata <= 8'd102) || out_tdata == 8'd66, "bad final char")
endmodule
bind number_to_ascii_formatter_unit n2a_checker u_chk (.clk, .rst_n, .out_tvalid,
  .out_tready, .out_tdata, .out_tlast);
